// File: hw/rtl/apq_pkg.sv
// ----------------------------------------------------------------------------
// apq_pkg
// shared codes, defaults and types of the alarm priority queue
// ----------------------------------------------------------------------------
package apq_pkg;

   localparam int NORMAL_DEPTH_DEF = 16;
   localparam int DATA_WIDTH_DEF   = 32;
   localparam int COUNT_WIDTH_DEF  = $clog2(NORMAL_DEPTH_DEF + 2);

   localparam int OPCODE_WIDTH = 2;
   localparam int STATUS_WIDTH = 3;

   // request opcodes
   localparam logic [OPCODE_WIDTH-1:0] OP_SEND_NORMAL = 2'd0;
   localparam logic [OPCODE_WIDTH-1:0] OP_SEND_ALARM  = 2'd1;
   localparam logic [OPCODE_WIDTH-1:0] OP_RECEIVE     = 2'd2;

   // response status codes
   localparam logic [STATUS_WIDTH-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_NULL    = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_BUSY    = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY   = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] ST_NOROOM  = 3'd4;

   // outcome of one request, passed from the core to the response stage
   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic                    recv_kind;
      logic                    from_alarm;
      logic                    from_mem;
   } apq_decision_type;

endpackage

// File: hw/rtl/apq_if.sv
// ----------------------------------------------------------------------------
// apq request and response channels
// valid/ready channels carrying the queue requests and responses
// ----------------------------------------------------------------------------
interface apq_req_if
   import apq_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
   logic                    valid;
   logic                    ready;
   logic [OPCODE_WIDTH-1:0] opcode;
   logic [DATA_WIDTH-1:0]   payload;

   modport source (output valid, output opcode, output payload, input ready);
   modport sink   (input valid, input opcode, input payload, output ready);
endinterface

interface apq_rsp_if
   import apq_pkg::*;
#(
   parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
);
   logic                    valid;
   logic                    ready;
   logic [STATUS_WIDTH-1:0] status;
   logic                    recv_kind;
   logic [DATA_WIDTH-1:0]   recv_data;
   logic [COUNT_WIDTH-1:0]  total_count;
   logic                    alarm_count;

   modport source (output valid, output status, output recv_kind, output recv_data,
                   output total_count, output alarm_count, input ready);
   modport sink   (input valid, input status, input recv_kind, input recv_data,
                   input total_count, input alarm_count, output ready);
endinterface

// File: hw/rtl/apq_store.sv
// ----------------------------------------------------------------------------
// apq_store
// message memory of the normal fifo, one write and one registered read port
// ----------------------------------------------------------------------------
module apq_store
   import apq_pkg::*;
#(
   parameter int NORMAL_DEPTH = NORMAL_DEPTH_DEF,
   parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
   localparam int PTR_WIDTH   = $clog2(NORMAL_DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [PTR_WIDTH-1:0]  wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [PTR_WIDTH-1:0]  rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] store_mem [NORMAL_DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/apq_core.sv
// ----------------------------------------------------------------------------
// apq_core
// request decode, fifo pointers and counts, alarm slot
// ----------------------------------------------------------------------------
module apq_core
   import apq_pkg::*;
#(
   parameter int NORMAL_DEPTH = NORMAL_DEPTH_DEF,
   parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
   localparam int PTR_WIDTH   = $clog2(NORMAL_DEPTH),
   localparam int CNT_WIDTH   = $clog2(NORMAL_DEPTH + 1),
   localparam int TOT_WIDTH   = $clog2(NORMAL_DEPTH + 2)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [OPCODE_WIDTH-1:0] opcode,
   input  logic [DATA_WIDTH-1:0]   payload,
   output apq_decision_type        decision,
   output logic [DATA_WIDTH-1:0]   alarm_data,
   output logic [TOT_WIDTH-1:0]    total_count,
   output logic                    alarm_count,
   output logic                    mem_wr_en,
   output logic [PTR_WIDTH-1:0]    mem_wr_addr,
   output logic                    mem_rd_en,
   output logic [PTR_WIDTH-1:0]    mem_rd_addr
);

   logic [PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CNT_WIDTH-1:0]  count_ff, count_in;
   logic                  alarm_held_ff, alarm_held_in;
   logic [DATA_WIDTH-1:0] alarm_data_ff, alarm_data_in;
   logic                  is_null;
   logic                  is_full;
   logic                  do_push;
   logic                  do_pop;

   function automatic logic [PTR_WIDTH-1:0] advance(input logic [PTR_WIDTH-1:0] ptr);
      return (ptr == PTR_WIDTH'(NORMAL_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign is_null = (payload == '0);
   assign is_full = (count_ff == CNT_WIDTH'(NORMAL_DEPTH));

   always_comb begin
      decision      = '{status: ST_OK, recv_kind: 1'b0, from_alarm: 1'b0, from_mem: 1'b0};
      do_push       = 1'b0;
      do_pop        = 1'b0;
      alarm_held_in = alarm_held_ff;
      alarm_data_in = alarm_data_ff;
      unique case (opcode)
         OP_SEND_NORMAL: begin
            priority if (is_null) begin
               decision.status = ST_NULL;
            end else if (is_full) begin
               decision.status = ST_NOROOM;
            end else begin
               do_push = accept;
            end
         end
         OP_SEND_ALARM: begin
            priority if (is_null) begin
               decision.status = ST_NULL;
            end else if (alarm_held_ff) begin
               decision.status = ST_BUSY;
            end else begin
               if (accept) begin
                  alarm_held_in = 1'b1;
                  alarm_data_in = payload;
               end
            end
         end
         OP_RECEIVE: begin
            priority if (alarm_held_ff) begin
               decision.recv_kind  = 1'b1;
               decision.from_alarm = 1'b1;
               if (accept) begin
                  alarm_held_in = 1'b0;
               end
            end else if (count_ff != '0) begin
               decision.from_mem = 1'b1;
               do_pop            = accept;
            end else begin
               decision.status = ST_EMPTY;
            end
         end
         default: begin
            // unused opcode: no effect
         end
      endcase
   end

   assign wr_ptr_in = do_push ? advance(wr_ptr_ff) : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? advance(rd_ptr_ff) : rd_ptr_ff;

   always_comb begin
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         count_ff      <= '0;
         alarm_held_ff <= 1'b0;
      end else begin
         rd_ptr_ff     <= rd_ptr_in;
         wr_ptr_ff     <= wr_ptr_in;
         count_ff      <= count_in;
         alarm_held_ff <= alarm_held_in;
      end
   end

   always_ff @(posedge clock) begin
      alarm_data_ff <= alarm_data_in;
   end

   assign mem_wr_en   = do_push;
   assign mem_wr_addr = wr_ptr_ff;
   assign mem_rd_en   = do_pop;
   assign mem_rd_addr = rd_ptr_ff;

   // counts after this request
   assign alarm_data  = alarm_data_ff;
   assign alarm_count = alarm_held_in;
   assign total_count = TOT_WIDTH'(count_in) + TOT_WIDTH'(alarm_held_in);

endmodule

// File: hw/rtl/alarm_priority_queue.sv
// ----------------------------------------------------------------------------
// alarm_priority_queue
// message fifo with one alarm slot served ahead of all normal messages
// ----------------------------------------------------------------------------
// A request is a normal send, an alarm send or a receive; each gives exactly
// one response with a status, the received message and its kind, and the
// total and alarm counts after the request. Normal messages sit in a
// single-port-write, registered-read memory of NORMAL_DEPTH entries; the
// alarm slot is a register. The block takes one request per cycle while the
// response side keeps up: queue state is updated when a request is taken,
// the memory read for a receive lands while the request waits in a holding
// stage, and a response register then presents the result. Requests are
// held off only while the holding stage is full and the response register
// is stalled. No clearing pass is needed after reset, since only entries
// that have been written are read.
module alarm_priority_queue
   import apq_pkg::*;
#(
   parameter int NORMAL_DEPTH = NORMAL_DEPTH_DEF,
   parameter int DATA_WIDTH   = DATA_WIDTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   apq_req_if.sink        req_bus,
   apq_rsp_if.source      rsp_bus
);

   localparam int PTR_WIDTH = $clog2(NORMAL_DEPTH);
   localparam int TOT_WIDTH = $clog2(NORMAL_DEPTH + 2);

   logic                   req_accept;
   apq_decision_type       decision;
   logic [DATA_WIDTH-1:0]  core_alarm_data;
   logic [TOT_WIDTH-1:0]   core_total;
   logic                   core_alarm_cnt;
   logic                   mem_wr_en;
   logic [PTR_WIDTH-1:0]   mem_wr_addr;
   logic                   mem_rd_en;
   logic [PTR_WIDTH-1:0]   mem_rd_addr;
   logic [DATA_WIDTH-1:0]  mem_rd_data;

   // holding stage, waits for the memory read
   logic                   s1_valid_ff, s1_valid_in;
   apq_decision_type       s1_dec_ff, s1_dec_in;
   logic [DATA_WIDTH-1:0]  s1_alarm_data_ff, s1_alarm_data_in;
   logic [TOT_WIDTH-1:0]   s1_total_ff, s1_total_in;
   logic                   s1_alarm_cnt_ff, s1_alarm_cnt_in;
   logic                   s1_move;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;
   logic                    rsp_kind_ff, rsp_kind_in;
   logic [DATA_WIDTH-1:0]   rsp_data_ff, rsp_data_in;
   logic [TOT_WIDTH-1:0]    rsp_total_ff, rsp_total_in;
   logic                    rsp_alarm_cnt_ff, rsp_alarm_cnt_in;

   // holding stage drains when the response register is free or emptying
   assign s1_move       = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_move;
   assign req_accept    = req_bus.valid && req_bus.ready;

   apq_core #(
      .NORMAL_DEPTH (NORMAL_DEPTH),
      .DATA_WIDTH   (DATA_WIDTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .opcode       (req_bus.opcode),
      .payload      (req_bus.payload),
      .decision     (decision),
      .alarm_data   (core_alarm_data),
      .total_count  (core_total),
      .alarm_count  (core_alarm_cnt),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr)
   );

   // normal sends write the payload, receives read the oldest entry
   apq_store #(
      .NORMAL_DEPTH (NORMAL_DEPTH),
      .DATA_WIDTH   (DATA_WIDTH)
   ) u_store (
      .clock        (clock),
      .wr_en        (mem_wr_en),
      .wr_addr      (mem_wr_addr),
      .wr_data      (req_bus.payload),
      .rd_en        (mem_rd_en),
      .rd_addr      (mem_rd_addr),
      .rd_data      (mem_rd_data)
   );

   // holding stage next values
   always_comb begin
      s1_valid_in      = s1_valid_ff;
      s1_dec_in        = s1_dec_ff;
      s1_alarm_data_in = s1_alarm_data_ff;
      s1_total_in      = s1_total_ff;
      s1_alarm_cnt_in  = s1_alarm_cnt_ff;
      priority if (req_accept) begin
         s1_valid_in      = 1'b1;
         s1_dec_in        = decision;
         s1_alarm_data_in = core_alarm_data;
         s1_total_in      = core_total;
         s1_alarm_cnt_in  = core_alarm_cnt;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         // nothing taken, nothing drained: hold
      end
   end

   // response register next values, data picked once the read has landed
   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_kind_in      = rsp_kind_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_total_in     = rsp_total_ff;
      rsp_alarm_cnt_in = rsp_alarm_cnt_ff;
      priority if (s1_move) begin
         rsp_valid_in     = 1'b1;
         rsp_status_in    = s1_dec_ff.status;
         rsp_kind_in      = s1_dec_ff.recv_kind;
         rsp_total_in     = s1_total_ff;
         rsp_alarm_cnt_in = s1_alarm_cnt_ff;
         priority if (s1_dec_ff.from_alarm) begin
            rsp_data_in = s1_alarm_data_ff;
         end else if (s1_dec_ff.from_mem) begin
            rsp_data_in = mem_rd_data;
         end else begin
            rsp_data_in = '0;
         end
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         // response stalled: hold
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      s1_dec_ff        <= s1_dec_in;
      s1_alarm_data_ff <= s1_alarm_data_in;
      s1_total_ff      <= s1_total_in;
      s1_alarm_cnt_ff  <= s1_alarm_cnt_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_kind_ff      <= rsp_kind_in;
      rsp_data_ff      <= rsp_data_in;
      rsp_total_ff     <= rsp_total_in;
      rsp_alarm_cnt_ff <= rsp_alarm_cnt_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.recv_kind   = rsp_kind_ff;
   assign rsp_bus.recv_data   = rsp_data_ff;
   assign rsp_bus.total_count = rsp_total_ff;
   assign rsp_bus.alarm_count = rsp_alarm_cnt_ff;

`ifndef SYNTHESIS
   // a request in the holding stage is never dropped before it drains
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff)
      else $error("holding stage lost a request");

   // a received alarm empties the alarm slot
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff |-> !rsp_alarm_cnt_ff && rsp_status_ff == ST_OK)
      else $error("alarm receive left the slot held");

   // counts never exceed the fifo depth plus the alarm slot
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_total_ff <= TOT_WIDTH'(NORMAL_DEPTH + 1)
                       && rsp_total_ff >= TOT_WIDTH'(rsp_alarm_cnt_ff))
      else $error("response count out of range");

   // the memory is read only when a request is taken, never alongside a write
   assert property (@(posedge clock) disable iff (reset)
      mem_rd_en |-> req_accept && !mem_wr_en)
      else $error("memory access outside an accepted request");
`endif

endmodule

// File: tb/sv/alarm_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// alarm_priority_queue_tb
// self-checking bench for the alarm priority queue: a clocked driver feeds
// requests from a backlog, a behavioural model forecasts each response, and a
// clocked monitor compares every response field against the forecast
// ----------------------------------------------------------------------------
module alarm_priority_queue_tb;
   import apq_pkg::*;

   localparam int DEPTH       = NORMAL_DEPTH_DEF;
   localparam int DWIDTH      = DATA_WIDTH_DEF;
   localparam int CWIDTH      = COUNT_WIDTH_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 10;
   localparam int PHASE_ITEMS = 350;

   // opcode the block has no use for, it must answer ok and change nothing
   localparam logic [OPCODE_WIDTH-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [OPCODE_WIDTH-1:0] opcode;
      logic [DWIDTH-1:0]       payload;
   } request_type;

   typedef struct {
      logic [STATUS_WIDTH-1:0] status;
      logic                    recv_kind;
      logic [DWIDTH-1:0]       recv_data;
      logic [CWIDTH-1:0]       total_count;
      logic                    alarm_count;
   } response_type;

   logic clock;
   logic reset;

   apq_req_if #(.DATA_WIDTH(DWIDTH))                     req_if ();
   apq_rsp_if #(.DATA_WIDTH(DWIDTH), .COUNT_WIDTH(CWIDTH)) rsp_if ();

   alarm_priority_queue #(
      .NORMAL_DEPTH (DEPTH),
      .DATA_WIDTH   (DWIDTH)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if.sink),
      .rsp_bus (rsp_if.source)
   );

   // requests waiting to be driven, and responses forecast but not yet seen
   request_type  request_backlog[$];
   response_type response_due[$];
   request_type  next_request;

   // behavioural copy of the queue state
   logic [DWIDTH-1:0] model_store [DEPTH];
   int                model_rd_ptr  = 0;
   int                model_wr_ptr  = 0;
   int                model_normals = 0;
   logic              model_alarm_held = 1'b0;
   logic [DWIDTH-1:0] model_alarm_msg  = '0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int error_count   = 0;
   int cycle_count   = 0;

   // ---------------------------------------------------------------------
   // clock and reset
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.opcode  = OP_SEND_NORMAL;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // queue model: applies one request, returns the response it should give
   // ---------------------------------------------------------------------
   function automatic response_type forecast_response(logic [OPCODE_WIDTH-1:0] op,
                                                      logic [DWIDTH-1:0] data);
      response_type r;
      r.status    = ST_OK;
      r.recv_kind = 1'b0;
      r.recv_data = '0;
      case (op)
         OP_SEND_NORMAL, OP_SEND_ALARM: begin
            // null check wins over both busy and no-room
            if (data == '0) begin
               r.status = ST_NULL;
            end else if (op == OP_SEND_ALARM) begin
               if (model_alarm_held) begin
                  r.status = ST_BUSY;
               end else begin
                  model_alarm_held = 1'b1;
                  model_alarm_msg  = data;
               end
            end else if (model_normals >= DEPTH) begin
               r.status = ST_NOROOM;
            end else begin
               model_store[model_wr_ptr] = data;
               model_wr_ptr  = (model_wr_ptr == DEPTH - 1) ? 0 : model_wr_ptr + 1;
               model_normals = model_normals + 1;
            end
         end
         OP_RECEIVE: begin
            // a held alarm always jumps the fifo
            if (model_alarm_held) begin
               r.recv_kind      = 1'b1;
               r.recv_data      = model_alarm_msg;
               model_alarm_held = 1'b0;
            end else if (model_normals > 0) begin
               r.recv_data   = model_store[model_rd_ptr];
               model_rd_ptr  = (model_rd_ptr == DEPTH - 1) ? 0 : model_rd_ptr + 1;
               model_normals = model_normals - 1;
            end else begin
               r.status = ST_EMPTY;
            end
         end
         default: ;
      endcase
      r.total_count = CWIDTH'(model_normals + (model_alarm_held ? 1 : 0));
      r.alarm_count = model_alarm_held;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // request driver: forecast on acceptance, then offer the next request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready)
            response_due.push_back(forecast_response(req_if.opcode, req_if.payload));
         if (!req_if.valid || req_if.ready) begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_request    = request_backlog.pop_front();
               req_if.valid   <= 1'b1;
               req_if.opcode  <= next_request.opcode;
               req_if.payload <= next_request.payload;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // response monitor and receiver back-pressure
   // ---------------------------------------------------------------------
   task automatic check_field(string field, logic [DWIDTH-1:0] expected,
                              logic [DWIDTH-1:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field,
                  expected, actual);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      response_type want;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
         if (rsp_if.valid && rsp_if.ready) begin
            if (response_due.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual status %0d data %0h",
                        $time, rsp_if.status, rsp_if.recv_data);
               error_count++;
            end else begin
               want = response_due.pop_front();
               check_field("status",      want.status,      rsp_if.status);
               check_field("recv_kind",   want.recv_kind,   rsp_if.recv_kind);
               check_field("recv_data",   want.recv_data,   rsp_if.recv_data);
               check_field("total_count", want.total_count, rsp_if.total_count);
               check_field("alarm_count", want.alarm_count, rsp_if.alarm_count);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_request(logic [OPCODE_WIDTH-1:0] op, logic [DWIDTH-1:0] data);
      request_type item;
      item.opcode  = op;
      item.payload = data;
      request_backlog.push_back(item);
   endtask

   // mostly random identifiers, with some null and edge values mixed in
   function automatic logic [DWIDTH-1:0] pick_payload();
      int roll;
      roll = $urandom_range(99);
      if (roll < 4)  return '0;
      if (roll < 7)  return '1;
      if (roll < 10) return DWIDTH'(1);
      return DWIDTH'($urandom());
   endfunction

   // test sequence waits until the backlog is sent and every forecast response has come back
   task automatic wait_for_drain();
      while (request_backlog.size() != 0 || req_if.valid || response_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic queue_directed();
      queue_request(OP_RECEIVE, '0);               // receive from empty
      queue_request(OP_SEND_NORMAL, '0);           // null normal send
      queue_request(OP_SEND_ALARM, '0);            // null alarm send
      queue_request(OP_UNUSED, 32'hDEAD_BEEF);     // unused opcode, ignored
      queue_request(OP_SEND_ALARM, 32'h0000_0001);
      queue_request(OP_SEND_ALARM, 32'hFFFF_FFFF); // alarm slot busy
      queue_request(OP_SEND_ALARM, '0);            // null beats busy
      for (int i = 0; i < DEPTH; i++)
         queue_request(OP_SEND_NORMAL, (i == 0) ? 32'hFFFF_FFFF : 32'h8000_0000 >> (i - 1));
      queue_request(OP_SEND_NORMAL, 32'h1234_5678); // fifo full
      queue_request(OP_SEND_NORMAL, '0);            // null beats no room
      queue_request(OP_RECEIVE, 32'hFFFF_FFFF);     // alarm jumps the queue
      queue_request(OP_RECEIVE, '0);
      queue_request(OP_RECEIVE, '0);
   endtask

   // bursts that lean towards filling, draining or neither, so the fifo
   // regularly reaches both full and empty
   task automatic queue_random(int count);
      int made;
      int burst;
      int lean;
      int roll;
      made = 0;
      while (made < count) begin
         burst = $urandom_range(40, 4);
         lean  = $urandom_range(2);
         for (int i = 0; i < burst && made < count; i++) begin
            roll = $urandom_range(99);
            if (roll < 3) begin
               queue_request(OP_UNUSED, DWIDTH'($urandom()));
            end else begin
               made++;
               if ((lean == 0 && roll < 75) || (lean == 1 && roll < 25) ||
                   (lean == 2 && roll < 50))
                  queue_request(($urandom_range(99) < 20) ? OP_SEND_ALARM : OP_SEND_NORMAL,
                                pick_payload());
               else
                  queue_request(OP_RECEIVE, DWIDTH'($urandom()));
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // watchdog
   // ---------------------------------------------------------------------
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("alarm_priority_queue_tb: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------------
   // test sequence: directed, then random phases with varied idling
   // ---------------------------------------------------------------------
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);

      // no idling on either side
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      queue_directed();
      queue_random(PHASE_ITEMS);
      wait_for_drain();

      // sender idles often
      send_idle_pct = 48;
      rsp_stall_pct = 0;
      queue_random(PHASE_ITEMS);
      wait_for_drain();

      // receiver stalls often
      send_idle_pct = 0;
      rsp_stall_pct = 48;
      queue_random(PHASE_ITEMS);
      wait_for_drain();

      // light idling on both sides
      send_idle_pct = 6;
      rsp_stall_pct = 6;
      queue_random(PHASE_ITEMS);
      wait_for_drain();

      // let any stray response show itself
      repeat (DRAIN_WAIT) @(negedge clock);

      if (error_count == 0 && response_due.size() == 0)
         $display("alarm_priority_queue_tb: done, clean");
      else
         $display("alarm_priority_queue_tb: done, errors");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/apq_pkg.sv
hw/rtl/apq_if.sv
hw/rtl/apq_store.sv
hw/rtl/apq_core.sv
hw/rtl/alarm_priority_queue.sv
tb/sv/alarm_priority_queue_tb.sv
